FILE: rtl/ppp_pkg.sv
// Shared types, constants and register codes for the point-to-pixel projection unit.
package ppp_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DIV_N_W   = 58;  // numerator magnitude width
  localparam int unsigned DIV_D_W   = 33;  // divisor width (2*zc)

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_QUAT    = 3'd0,
    REG_TRANSLATION = 3'd1,
    REG_FOCAL_X     = 3'd2,
    REG_FOCAL_Y     = 3'd3,
    REG_CENTER      = 3'd4,
    REG_SCALE       = 3'd5,
    REG_FOV_MARGIN  = 3'd6,
    REG_IMAGE_SIZE  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_INSIDE  = 2'd0,
    ST_BEHIND  = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_e;

  localparam logic [63:0] ROT_QUAT_RST   = 64'h4000_0000_0000_0000;
  localparam logic [23:0] SCALE_RST      = 24'd65536;
  localparam logic [31:0] IMAGE_SIZE_RST = {16'd640, 16'd480};

endpackage

FILE: rtl/point_to_pixel_projection_unit.sv
// Top level of the point-to-pixel projection unit: config registers and the projection pipeline.
//
// Usage: world points arrive one per beat on the s_axis channel (x, y, z, signed 24-bit,
// 1/1024 m). Each point is rotated by the configured quaternion, translated, divided by its
// camera depth and mapped through the focal lengths and principal point. One result beat per
// point leaves on m_axis: scaled pixel u and v (signed 32-bit, 1/256 pixel) in tdata and the
// status in tuser (inside, behind camera, outside the margin rectangle).
// Registers are written through the cfg channel (index, data); cfg_ready_o is always high.
// Write them only while no point is in flight.
// The 58-stage depth divider makes up most of the pipeline from accept to result.
// Throughput is one point per cycle while the receiver does not stall.
// Reset clears all valid bits and loads the register defaults (identity rotation, 640x480,
// unit scale). When the receiver stalls, the whole pipeline holds and s_axis_tready drops;
// nothing is lost or repeated.
module point_to_pixel_projection_unit import ppp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [71:0]          s_axis_tdata,   // point_x[23:0], point_y[47:24], point_z[71:48]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,   // pixel_u[31:0], pixel_v[63:32]
  output logic [1:0]           m_axis_tuser,   // status[1:0]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  localparam logic signed [33:0] ONE_R = 34'sd268435456;
  localparam logic signed [59:0] HALF  = 60'sd134217728;

  function automatic logic axis_inside(input logic signed [59:0] p0,
                                       input logic [15:0] m, input logic [15:0] size);
    logic signed [79:0] lhs1, rhs1, c, lhs2, rhs2;
    lhs1 = 80'(p0) <<< 8;
    rhs1 = $signed(80'(32'(m) * 32'(size))) + 80'sd65536;
    c    = (80'(p0) + 80'sd255) >>> 8;
    lhs2 = c <<< 16;
    rhs2 = $signed(80'((17'd65536 - 17'(m)) * 33'(size)));
    return (lhs1 >= rhs1) && (lhs2 < rhs2);
  endfunction

  // ---------------- configuration registers ----------------
  logic [63:0] rot_q;
  logic [62:0] trans_q;
  logic [23:0] fx_q, fy_q, scale_q;
  logic [47:0] center_q;
  logic [15:0] margin_q;
  logic [31:0] size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q    <= ROT_QUAT_RST;
      trans_q  <= '0;
      fx_q     <= '0;
      fy_q     <= '0;
      center_q <= '0;
      scale_q  <= SCALE_RST;
      margin_q <= '0;
      size_q   <= IMAGE_SIZE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ROT_QUAT:    rot_q    <= cfg_data_i;
        REG_TRANSLATION: trans_q  <= cfg_data_i[62:0];
        REG_FOCAL_X:     fx_q     <= cfg_data_i[23:0];
        REG_FOCAL_Y:     fy_q     <= cfg_data_i[23:0];
        REG_CENTER:      center_q <= cfg_data_i[47:0];
        REG_SCALE:       scale_q  <= cfg_data_i[23:0];
        REG_FOV_MARGIN:  margin_q <= cfg_data_i[15:0];
        REG_IMAGE_SIZE:  size_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] qw, qx, qy, qz;
  assign qw = $signed(rot_q[63:48]);
  assign qx = $signed(rot_q[47:32]);
  assign qy = $signed(rot_q[31:16]);
  assign qz = $signed(rot_q[15:0]);

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- stage 1: point in, quaternion products ----------------
  logic               v1_q;
  logic signed [23:0] px_q, py_q, pz_q;
  logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= $signed(s_axis_tdata[23:0]);
      py_q <= $signed(s_axis_tdata[47:24]);
      pz_q <= $signed(s_axis_tdata[71:48]);
      xx_q <= qx * qx;
      yy_q <= qy * qy;
      zz_q <= qz * qz;
      xy_q <= qx * qy;
      xz_q <= qx * qz;
      yz_q <= qy * qz;
      wx_q <= qw * qx;
      wy_q <= qw * qy;
      wz_q <= qw * qz;
    end
  end

  // ---------------- stage 2: matrix entries times point ----------------
  logic signed [33:0] r [9];
  always_comb begin
    r[0] = ONE_R - ((34'(yy_q) + 34'(zz_q)) <<< 1);
    r[1] = (34'(xy_q) - 34'(wz_q)) <<< 1;
    r[2] = (34'(xz_q) + 34'(wy_q)) <<< 1;
    r[3] = (34'(xy_q) + 34'(wz_q)) <<< 1;
    r[4] = ONE_R - ((34'(xx_q) + 34'(zz_q)) <<< 1);
    r[5] = (34'(yz_q) - 34'(wx_q)) <<< 1;
    r[6] = (34'(xz_q) - 34'(wy_q)) <<< 1;
    r[7] = (34'(yz_q) + 34'(wx_q)) <<< 1;
    r[8] = ONE_R - ((34'(xx_q) + 34'(yy_q)) <<< 1);
  end

  logic               v2_q;
  logic signed [57:0] prod_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[3*i]   <= 58'(r[3*i])   * 58'(px_q);
        prod_q[3*i+1] <= 58'(r[3*i+1]) * 58'(py_q);
        prod_q[3*i+2] <= 58'(r[3*i+2]) * 58'(pz_q);
      end
    end
  end

  // ---------------- stage 3: row sums, round, translate ----------------
  logic signed [59:0] sx, sy, sz;
  always_comb begin
    sx = 60'(prod_q[0]) + 60'(prod_q[1]) + 60'(prod_q[2]) + HALF;
    sy = 60'(prod_q[3]) + 60'(prod_q[4]) + 60'(prod_q[5]) + HALF;
    sz = 60'(prod_q[6]) + 60'(prod_q[7]) + 60'(prod_q[8]) + HALF;
  end

  logic               v3_q;
  logic signed [31:0] xc_q, yc_q, zc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xc_q <= $signed(sx[59:28]) + 32'($signed(trans_q[62:42]));
      yc_q <= $signed(sy[59:28]) + 32'($signed(trans_q[41:21]));
      zc_q <= $signed(sz[59:28]) + 32'($signed(trans_q[20:0]));
    end
  end

  // ---------------- stage 4: numerators and divisor ----------------
  logic               behind;
  logic signed [57:0] nu, nv;
  always_comb begin
    behind = zc_q < 32'sd1;
    nu = ((58'(xc_q) * $signed({34'd0, fx_q})) <<< 1) + 58'(zc_q);
    nv = ((58'(yc_q) * $signed({34'd0, fy_q})) <<< 1) + 58'(zc_q);
  end

  logic                v4_q, behind4_q, negu4_q, negv4_q;
  logic [DIV_N_W-1:0]  magu4_q, magv4_q;
  logic [DIV_D_W-1:0]  den4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      behind4_q <= behind;
      negu4_q   <= nu[57];
      negv4_q   <= nv[57];
      magu4_q   <= nu[57] ? DIV_N_W'(-nu) : DIV_N_W'(nu);
      magv4_q   <= nv[57] ? DIV_N_W'(-nv) : DIV_N_W'(nv);
      den4_q    <= behind ? DIV_D_W'(1) : {zc_q, 1'b0};
    end
  end

  // ---------------- divider ----------------
  logic               vdu, vdv, rnz_u, rnz_v;
  logic [DIV_N_W-1:0] qu, qv;
  logic [1:0]         tag_u;
  logic               tag_v;

  ppp_divider #(.N_W(DIV_N_W), .D_W(DIV_D_W), .TAG_W(2)) u_div_u (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .num_i(magu4_q), .den_i(den4_q),
    .tag_i({behind4_q, negu4_q}), .valid_o(vdu), .quot_o(qu), .rem_nz_o(rnz_u),
    .tag_o(tag_u)
  );

  ppp_divider #(.N_W(DIV_N_W), .D_W(DIV_D_W), .TAG_W(1)) u_div_v (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .num_i(magv4_q), .den_i(den4_q),
    .tag_i(negv4_q), .valid_o(vdv), .quot_o(qv), .rem_nz_o(rnz_v), .tag_o(tag_v)
  );

  // ---------------- stage A: floor sign fix, add principal point ----------------
  logic signed [59:0] qsu, qsv;
  always_comb begin
    qsu = 60'(qu);
    qsv = 60'(qv);
    if (tag_u[0]) qsu = rnz_u ? -(qsu + 60'sd1) : -qsu;
    if (tag_v)    qsv = rnz_v ? -(qsv + 60'sd1) : -qsv;
  end

  logic               va_q, behinda_q;
  logic signed [59:0] u0_q, v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en) va_q <= vdu && vdv;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      behinda_q <= tag_u[1];
      u0_q      <= qsu + $signed({36'd0, center_q[47:24]});
      v0_q      <= qsv + $signed({36'd0, center_q[23:0]});
    end
  end

  // ---------------- stage B: inside test, scale partial products ----------------
  logic        negu, negv;
  logic [58:0] magu, magv;
  always_comb begin
    negu = u0_q[59];
    negv = v0_q[59];
    magu = negu ? 59'(-u0_q) : 59'(u0_q);
    magv = negv ? 59'(-v0_q) : 59'(v0_q);
  end

  logic        vb_q, behindb_q, insideb_q, negub_q, negvb_q, satub_q, satvb_q;
  logic [56:0] hsu_q, hsv_q;
  logic [39:0] lsu_q, lsv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en) vb_q <= va_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      behindb_q <= behinda_q;
      insideb_q <= axis_inside(u0_q, margin_q, size_q[31:16]) &&
                   axis_inside(v0_q, margin_q, size_q[15:0]);
      negub_q   <= negu;
      negvb_q   <= negv;
      satub_q   <= (|magu[58:49]) && (|scale_q);
      satvb_q   <= (|magv[58:49]) && (|scale_q);
      hsu_q     <= magu[48:16] * scale_q;
      hsv_q     <= magv[48:16] * scale_q;
      lsu_q     <= magu[15:0] * scale_q;
      lsv_q     <= magv[15:0] * scale_q;
    end
  end

  // ---------------- stage C: round, saturate, output register ----------------
  function automatic logic [31:0] finish(input logic neg, input logic sat,
                                         input logic [56:0] hs, input logic [39:0] ls);
    logic [57:0] rr;
    rr = 58'(hs) + 58'((ls + 40'h8000) >> 16);
    if (!neg) begin
      if (sat || rr > 58'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return rr[31:0];
    end
    if (sat || rr > 58'h8000_0000) rr = 58'h8000_0000;
    return 32'(-rr);
  endfunction

  logic        mv_q;
  logic [31:0] pu_q, pv_q;
  logic [1:0]  st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mv_q <= 1'b0;
    else if (en) mv_q <= vb_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (behindb_q) begin
        pu_q <= '0;
        pv_q <= '0;
        st_q <= ST_BEHIND;
      end else begin
        pu_q <= finish(negub_q, satub_q, hsu_q, lsu_q);
        pv_q <= finish(negvb_q, satvb_q, hsv_q, lsv_q);
        st_q <= insideb_q ? ST_INSIDE : ST_OUTSIDE;
      end
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {pv_q, pu_q};
  assign m_axis_tuser  = st_q;

  // ---------------- assertions ----------------
  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_BEHIND) |-> m_axis_tdata == 64'd0)
    else $error("behind-camera beat carries a nonzero pixel");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("undefined status code");

  a_div_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vdu == vdv)
    else $error("divider lanes out of step");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

FILE: rtl/ppp_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
module ppp_divider import ppp_pkg::*; #(
  parameter int unsigned N_W   = DIV_N_W,
  parameter int unsigned D_W   = DIV_D_W,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [N_W-1:0]   num_i,
  input  logic [D_W-1:0]   den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [N_W-1:0]   quot_o,
  output logic             rem_nz_o,
  output logic [TAG_W-1:0] tag_o
);

  logic             vld_a [0:N_W];
  logic [N_W-1:0]   num_a [0:N_W];
  logic [D_W-1:0]   den_a [0:N_W];
  logic [D_W-1:0]   rem_a [0:N_W];
  logic [TAG_W-1:0] tag_a [0:N_W];

  assign vld_a[0] = valid_i;
  assign num_a[0] = num_i;
  assign den_a[0] = den_i;
  assign rem_a[0] = '0;
  assign tag_a[0] = tag_i;

  for (genvar k = 0; k < N_W; k++) begin : g_stage
    logic [D_W:0]   shifted;
    logic           ge;
    logic [D_W:0]   diff;

    always_comb begin
      shifted = {rem_a[k], num_a[k][N_W-1]};
      ge      = shifted >= {1'b0, den_a[k]};
      diff    = shifted - {1'b0, den_a[k]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_a[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_a[k+1] <= vld_a[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_a[k+1] <= {num_a[k][N_W-2:0], ge};
        den_a[k+1] <= den_a[k];
        rem_a[k+1] <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
        tag_a[k+1] <= tag_a[k];
      end
    end
  end

  assign valid_o  = vld_a[N_W];
  assign quot_o   = num_a[N_W];
  assign rem_nz_o = |rem_a[N_W];
  assign tag_o    = tag_a[N_W];

endmodule
